[rtl/mfs_pkg.sv]
// Shared types and constants for the MPEG audio frame sync finder.
`default_nettype none

package mfs_pkg;

    // Header check collects at most this many bytes (ID3 / ea3 header length)
    localparam int HDR_LEN      = 10;
    // EA3 length field ends at this byte count
    localparam int EA3_LEN_END  = 6;
    // ID3 footer adds this many bytes
    localparam int FOOTER_EXTRA = 10;
    localparam int FOOTER_BIT   = 4;

    // Stored header bytes: offsets 4..8 are the only ones read later
    localparam int HB_FIRST = 4;
    localparam int HB_DEPTH = 5;

    localparam int SKIP_BITS   = 30;
    localparam int OFFSET_BITS = 32;
    localparam int IDX_BITS    = 4;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] SYNC_MASK = 8'hE0;

    // Header tags
    localparam logic [7:0] TAG_ID3 [3] = '{8'h49, 8'h44, 8'h33};
    localparam logic [7:0] TAG_EA3_LO [3] = '{8'h65, 8'h61, 8'h33};
    localparam logic [7:0] TAG_EA3_UP [3] = '{8'h45, 8'h41, 8'h33};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_start;
        logic       stream_end;
    } t_item;

    typedef struct packed {
        logic                   status;
        logic [OFFSET_BITS-1:0] sync_offset;
    } t_result;

endpackage

`default_nettype wire

[rtl/mp3_frame_sync_finder.sv]
// Stages: input register, single-step parser, result register, in that order.
// Throughput: one byte per cycle while downstream does not hold stall high.
// A waiting result stalls the input side only while downstream holds stall high.
// Reset (synchronous, active low) empties both registers and puts the parser at a
// stream start: header check, position 0.
`default_nettype none

module mp3_frame_sync_finder #(
    parameter int POSITION_BITS = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_stall,
    input  wire  [7:0]                     i_data_byte,
    input  wire                            i_stream_start,
    input  wire                            i_stream_end,
    output logic                           o_valid,
    input  wire                            i_stall,
    output logic                           o_status,
    output logic [mfs_pkg::OFFSET_BITS-1:0] o_sync_offset
);
    import mfs_pkg::*;

    t_item   in_item, held_item;
    t_result res, out_res;
    logic    held_valid, out_free, step, res_valid;

    assign in_item.data_byte    = i_data_byte;
    assign in_item.stream_start = i_stream_start;
    assign in_item.stream_end   = i_stream_end;

    // Parser advances when a byte is held and the result register can take a result
    assign step = held_valid && out_free;

    mfs_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (in_item),
        .o_stall (o_stall),
        .i_take  (step),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    mfs_parser #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (held_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    mfs_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_status      = out_res.status;
    assign o_sync_offset = out_res.sync_offset;

endmodule

`default_nettype wire

[rtl/mfs_in_stage.sv]
// Input register stage: holds one accepted byte for the parser.
`default_nettype none

module mfs_in_stage (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    input  mfs_pkg::t_item i_item,
    output logic           o_stall,
    input  wire            i_take,
    output logic           o_valid,
    output mfs_pkg::t_item o_item
);
    import mfs_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  load;

    // Stall only while a held byte cannot move on this cycle
    assign o_stall = r_valid && !i_take;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[rtl/mfs_parser.sv]
// Stream parser: header check, header skip and sync search, one byte per step.
`default_nettype none

module mfs_parser #(
    parameter int POSITION_BITS = 32
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_step,
    input  mfs_pkg::t_item   i_item,
    output logic             o_res_valid,
    output mfs_pkg::t_result o_res
);
    import mfs_pkg::*;

    typedef enum logic [1:0] {
        PH_CHECK,
        PH_SKIP,
        PH_SEARCH,
        PH_DONE
    } t_phase;

    // Parser state
    logic [POSITION_BITS-1:0] r_pos,  n_pos;
    t_phase                   r_phase, n_phase;
    logic [IDX_BITS-1:0]      r_idx,  n_idx;
    logic [SKIP_BITS-1:0]     r_skip, n_skip;
    logic                     r_pff,  n_pff;
    // Running tag prefix matches
    logic                     r_m_id, r_m_el, r_m_eu;
    logic                     n_m_id, n_m_el, n_m_eu;
    // Running sync search over collected header bytes
    logic                     r_hff,  n_hff;
    logic                     r_hfound, n_hfound;
    logic [POSITION_BITS-1:0] r_hoff, n_hoff;

    // Header bytes 4..8, undefined until written
    logic [7:0] r_hb [HB_DEPTH];

    // Effective state after a possible stream start
    logic [POSITION_BITS-1:0] c_pos;
    t_phase                   c_phase;
    logic [IDX_BITS-1:0]      c_idx, idx_w;
    logic [SKIP_BITS-1:0]     c_skip, skip_dec;
    logic                     c_pff;
    logic                     first;
    logic [1:0]               tag_sel;
    logic                     tag_region;
    logic [7:0]               b;
    logic                     top3, is_ff, pair;
    logic                     id_hit, ea_hit;
    logic [15:0]              ea_len;
    logic [SKIP_BITS-1:0]     ea_rem, id_size, rem;
    logic                     do_skip;
    logic                     hb_we;
    logic [IDX_BITS-1:0]      hb_off;
    logic [2:0]               hb_wa;
    logic                     found, report;
    logic [POSITION_BITS-1:0] off;

    assign b     = i_item.data_byte;
    assign top3  = (b & SYNC_MASK) == SYNC_MASK;
    assign is_ff = (b == SYNC_BYTE);

    always_comb begin
        c_pos   = i_item.stream_start ? '0 : r_pos;
        c_phase = i_item.stream_start ? PH_CHECK : r_phase;
        c_idx   = i_item.stream_start ? '0 : r_idx;
        c_skip  = i_item.stream_start ? '0 : r_skip;
        c_pff   = i_item.stream_start ? 1'b0 : r_pff;
    end

    assign idx_w      = (c_idx >= IDX_BITS'(HDR_LEN)) ? '0 : c_idx;
    assign first      = (idx_w == '0);
    assign tag_region = (idx_w < IDX_BITS'(3));
    assign tag_sel    = idx_w[1:0];

    // Tag prefix tracking: bytes past the third always match
    always_comb begin
        n_m_id = (first || r_m_id) && (!tag_region || b == TAG_ID3[tag_sel]);
        n_m_el = (first || r_m_el) && (!tag_region || b == TAG_EA3_LO[tag_sel]);
        n_m_eu = (first || r_m_eu) && (!tag_region || b == TAG_EA3_UP[tag_sel]);
    end

    assign id_hit = n_m_id || n_m_el;
    assign ea_hit = n_m_eu;

    // Sync pairs among the collected bytes, first one kept
    always_comb begin
        pair     = !first && r_hff && top3;
        n_hff    = is_ff;
        n_hfound = (!first && r_hfound) || pair;
        n_hoff   = (!first && r_hfound) ? r_hoff : c_pos - 1'b1;
    end

    // Header lengths
    assign ea_len  = {r_hb[0], b};
    assign ea_rem  = (ea_len > 16'(EA3_LEN_END)) ?
                     SKIP_BITS'(ea_len) - SKIP_BITS'(EA3_LEN_END) : '0;
    assign id_size = SKIP_BITS'({r_hb[2][6:0], r_hb[3][6:0], r_hb[4][6:0], b[6:0]})
                   + (r_hb[1][FOOTER_BIT] ? SKIP_BITS'(FOOTER_EXTRA) : '0);
    assign skip_dec = (c_skip != '0) ? c_skip - 1'b1 : '0;

    // Next state and result
    always_comb begin
        n_pos   = c_pos + 1'b1;
        n_phase = c_phase;
        n_idx   = c_idx;
        n_skip  = c_skip;
        n_pff   = c_pff;
        found   = 1'b0;
        off     = '0;
        do_skip = 1'b0;
        rem     = '0;

        case (c_phase)
            PH_CHECK: begin
                n_idx = idx_w + 1'b1;
                if (!id_hit && !ea_hit) begin
                    // No header: collected tag bytes hold no sync pair
                    n_phase = PH_SEARCH;
                    n_idx   = '0;
                    n_pff   = is_ff;
                end else if (ea_hit && idx_w == IDX_BITS'(EA3_LEN_END - 1)) begin
                    do_skip = 1'b1;
                    rem     = ea_rem;
                end else if (id_hit && idx_w == IDX_BITS'(HDR_LEN - 1)) begin
                    do_skip = 1'b1;
                    rem     = id_size;
                end
                if (do_skip) begin
                    n_idx = '0;
                    if (rem == '0) begin
                        n_phase = PH_CHECK;
                        n_pff   = 1'b0;
                    end else begin
                        n_phase = PH_SKIP;
                        n_skip  = rem;
                    end
                end
            end
            PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    n_phase = PH_CHECK;
                    n_idx   = '0;
                    n_pff   = 1'b0;
                end
            end
            PH_SEARCH: begin
                if (c_pff && top3) begin
                    found = 1'b1;
                    off   = c_pos - 1'b1;
                end
                n_pff = is_ff;
            end
            default: begin
            end
        endcase

        // End of stream: collected header bytes are searched too
        report = found;
        if (!found && i_item.stream_end && n_phase != PH_DONE) begin
            if (n_phase == PH_CHECK && n_idx != '0 && n_hfound) begin
                found = 1'b1;
                off   = n_hoff;
            end
            report = 1'b1;
        end
        if (report) begin
            n_phase = PH_DONE;
            n_idx   = '0;
        end
    end

    assign o_res_valid       = report;
    assign o_res.status      = !found;
    assign o_res.sync_offset = found ? OFFSET_BITS'(off) : '0;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_phase  <= PH_CHECK;
            r_idx    <= '0;
            r_skip   <= '0;
            r_pff    <= 1'b0;
            r_m_id   <= 1'b0;
            r_m_el   <= 1'b0;
            r_m_eu   <= 1'b0;
            r_hff    <= 1'b0;
            r_hfound <= 1'b0;
            r_hoff   <= '0;
        end else if (i_step) begin
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_skip   <= n_skip;
            r_pff    <= n_pff;
            r_m_id   <= n_m_id;
            r_m_el   <= n_m_el;
            r_m_eu   <= n_m_eu;
            r_hff    <= n_hff;
            r_hfound <= n_hfound;
            r_hoff   <= n_hoff;
        end
    end

    // Header byte store, written during header check only
    assign hb_off = idx_w - IDX_BITS'(HB_FIRST);
    assign hb_wa  = hb_off[2:0];
    assign hb_we  = i_step && c_phase == PH_CHECK && idx_w >= IDX_BITS'(HB_FIRST)
                    && idx_w < IDX_BITS'(HB_FIRST + HB_DEPTH);

    always_ff @(posedge i_clk) begin
        if (hb_we) begin
            r_hb[hb_wa] <= b;
        end
    end

endmodule

`default_nettype wire

[rtl/mfs_out_stage.sv]
// Result register: holds one result until the downstream side takes it.
`default_nettype none

module mfs_out_stage (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_load,
    input  mfs_pkg::t_result i_res,
    output logic             o_free,
    input  wire              i_stall,
    output logic             o_valid,
    output mfs_pkg::t_result o_res
);
    import mfs_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Free when empty or when the held result transfers this cycle
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire
